### rtl/escaped_length_frame_link_codec_top_assert.svh
// assertion macros for the escaped length frame link codec
`ifndef ESCAPED_LENGTH_FRAME_LINK_CODEC_TOP_ASSERT_SVH
`define ESCAPED_LENGTH_FRAME_LINK_CODEC_TOP_ASSERT_SVH

// checked property, masked while reset is asserted
`define ELFC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("elfc assertion failed");

// checked property, also live during reset
`define ELFC_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("elfc reset assertion failed");

`endif

### rtl/elfc_pkg.sv
`default_nettype none

package elfc_pkg;

    // link byte codes
    localparam logic [7:0] ByteStart  = 8'hF0;
    localparam logic [7:0] ByteEsc    = 8'hF1;
    localparam logic [7:0] ByteAck    = 8'hF2;
    localparam logic [7:0] ByteErrLo  = 8'hF3;
    localparam logic [7:0] ByteMask7  = 8'h7F;
    localparam logic [7:0] ByteHigh   = 8'h80;
    localparam logic [7:0] ByteReject = 8'hFF;
    localparam logic [7:0] ByteErrFc  = 8'hFC;

    // start marker, two length bytes
    localparam int HdrBytes = 3;

    localparam logic KIND_RX = 1'b0;
    localparam logic KIND_TX = 1'b1;

    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = 2;
    localparam int QueueCntW  = 3;

    typedef enum logic [2:0] {
        EV_STORED   = 3'd0,
        EV_DONE     = 3'd1,
        EV_LOG_DONE = 3'd2,
        EV_ACK      = 3'd3,
        EV_ERROR    = 3'd4,
        EV_OVERFLOW = 3'd5,
        EV_LINK     = 3'd6
    } t_event;

    typedef enum logic [3:0] {
        ERR_UNKNOWN_CMD = 4'd0,
        ERR_BAD_SIZE    = 4'd1,
        ERR_BUSY        = 4'd2,
        ERR_NO_MEMORY   = 4'd3,
        ERR_TOO_MUCH    = 4'd4,
        ERR_ONCE_ONLY   = 4'd5,
        ERR_UNAUTH      = 4'd6,
        ERR_LOCKED      = 4'd7,
        ERR_BAD_TIME    = 4'd8,
        ERR_RESEND      = 4'd9,
        ERR_OTHER       = 4'd10
    } t_err;

    typedef struct packed {
        logic       kind;
        logic [7:0] byte_in;
        logic       tx_frame_start;
    } t_in_item;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] rx_byte;
        logic [9:0] rx_index;
        t_err       error_code;
        logic       link_valid;
        logic [7:0] link_byte;
        logic       last;
    } t_out_item;

    // queue entry: a transmit job or one finished receive result
    typedef struct packed {
        logic       is_tx;
        logic       tx_start;
        logic [7:0] tx_byte;
        t_out_item  res;
    } t_cmd;

    // error reply byte to dense error code
    function automatic t_err map_error(input logic [7:0] b);
        t_err e;
        case (b)
            8'hF3:     e = ERR_UNKNOWN_CMD;
            8'hF4:     e = ERR_BAD_SIZE;
            8'hF6:     e = ERR_BUSY;
            8'hF7:     e = ERR_NO_MEMORY;
            8'hF8:     e = ERR_TOO_MUCH;
            8'hF9:     e = ERR_ONCE_ONLY;
            8'hFA:     e = ERR_UNAUTH;
            8'hFB:     e = ERR_LOCKED;
            ByteErrFc: e = ERR_BAD_TIME;
            8'hFF:     e = ERR_RESEND;
            default:   e = ERR_OTHER;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

### rtl/elfc_if.sv
`default_nettype none

interface elfc_in_if;
    import elfc_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface elfc_out_if;
    import elfc_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface elfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/escaped_length_frame_link_codec_top.sv
// each result is written into the job queue and then registered in the output register
// one receive beat is taken per cycle; a transmit item expands into 1 to 3 link bytes,
// and the output register issues one beat per cycle while the output is ready
// the input side keeps accepting while the 4-entry job queue has room
// reset: synchronous, active low; clears frame state, log code, queue, output
`default_nettype none

module escaped_length_frame_link_codec_top
    import elfc_pkg::*;
#(
    parameter int MAX_FRAME = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    elfc_in_if.sink     i_in,
    elfc_out_if.source  o_out,
    elfc_cfg_if.sink    i_cfg
);

    // job queue between the deframer front and the beat issuer
    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_pop;
    logic q_empty;
    t_cmd q_head;

    // the log code register can always take a write beat
    assign i_cfg.ready = 1'b1;

    // front: classifies each beat, runs the frame state, builds the result
    elfc_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_data   (i_in.data),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_cmd  (push_cmd)
    );

    // short queue lets the front run on while the output side stalls
    elfc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_empty    (q_empty),
        .o_head     (q_head)
    );

    // back: expands transmit jobs into escaped link bytes, registers output
    elfc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_head      (q_head),
        .o_pop       (q_pop),
        .o_out_valid (o_out.valid),
        .o_out_data  (o_out.data),
        .i_out_ready (o_out.ready)
    );

endmodule

`default_nettype wire

### rtl/elfc_front.sv
`default_nettype none

module elfc_front
    import elfc_pkg::*;
#(
    parameter int MAX_FRAME = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_ready,
    input  logic       i_cfg_valid,
    input  logic [7:0] i_cfg_data,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_push_cmd
);

    localparam int CntW = $clog2(MAX_FRAME + 1);
    localparam int CmpW = (CntW > 17) ? CntW : 17;
    localparam logic [CntW-1:0] MaxCount = CntW'(MAX_FRAME);

    logic [CntW-1:0] r_count, n_count;
    logic            r_esc, n_esc;
    logic [15:0]     r_len, n_len;
    logic [7:0]      r_cmd, n_cmd;
    logic [7:0]      r_log;

    logic            accept;
    logic            store;
    logic            done;
    logic [7:0]      b;
    logic [CntW-1:0] idx;
    logic [CntW-1:0] idx_next;
    logic [CmpW-1:0] idx_ext;
    logic [CmpW-1:0] next_ext;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign idx_next   = idx + CntW'(1);
    assign idx_ext    = CmpW'(idx);
    assign next_ext   = CmpW'(idx_next);

    always_comb begin
        n_count    = r_count;
        n_esc      = r_esc;
        n_len      = r_len;
        n_cmd      = r_cmd;
        o_push     = 1'b0;
        o_push_cmd = '0;
        b          = i_in_data.byte_in;
        idx        = r_count;
        store      = 1'b0;
        done       = 1'b0;
        if (accept) begin
            if (i_in_data.kind == KIND_TX) begin
                o_push             = 1'b1;
                o_push_cmd.is_tx    = 1'b1;
                o_push_cmd.tx_start = i_in_data.tx_frame_start;
                o_push_cmd.tx_byte  = b;
            end else if (r_count == '0 && b != ByteStart) begin
                // no frame open: control bytes and rejects
                o_push = 1'b1;
                if (b == ByteAck) begin
                    o_push_cmd.res.event_res = EV_ACK;
                end else if (b >= ByteErrLo) begin
                    o_push_cmd.res.event_res  = EV_ERROR;
                    o_push_cmd.res.error_code = map_error(b);
                end else begin
                    o_push_cmd.res.event_res  = EV_LINK;
                    o_push_cmd.res.link_valid = 1'b1;
                    o_push_cmd.res.link_byte  = ByteReject;
                end
            end else begin
                store = 1'b1;
                if (b == ByteStart) begin
                    idx   = '0;
                    n_esc = 1'b0;
                end else if (r_esc) begin
                    b     = b | ByteHigh;
                    n_esc = 1'b0;
                end else if (b == ByteEsc) begin
                    n_esc = 1'b1;
                    store = 1'b0;
                end
                if (store) begin
                    o_push = 1'b1;
                    if (idx >= MaxCount) begin
                        n_count = '0;
                        n_esc   = 1'b0;
                        o_push_cmd.res.event_res = EV_OVERFLOW;
                    end else begin
                        if (idx == CntW'(1)) begin
                            n_len[15:8] = b;
                        end else if (idx == CntW'(2)) begin
                            n_len[7:0] = b;
                        end else if (idx == CntW'(3)) begin
                            n_cmd = b;
                        end
                        n_count = idx_next;
                        done = (next_ext > CmpW'(HdrBytes)) &&
                               (next_ext == CmpW'(n_len) + CmpW'(HdrBytes));
                        o_push_cmd.res.rx_byte  = b;
                        o_push_cmd.res.rx_index = idx_ext[9:0];
                        if (done) begin
                            n_count = '0;
                            n_esc   = 1'b0;
                            o_push_cmd.res.event_res  = (n_cmd == r_log) ? EV_LOG_DONE
                                                                         : EV_DONE;
                            o_push_cmd.res.link_valid = 1'b1;
                            o_push_cmd.res.link_byte  = ByteAck;
                        end else begin
                            o_push_cmd.res.event_res = EV_STORED;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_esc   <= 1'b0;
            r_len   <= '0;
            r_cmd   <= '0;
            r_log   <= '0;
        end else begin
            r_count <= n_count;
            r_esc   <= n_esc;
            r_len   <= n_len;
            r_cmd   <= n_cmd;
            if (i_cfg_valid) begin
                r_log <= i_cfg_data;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/elfc_queue.sv
`default_nettype none

module elfc_queue
    import elfc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd                 r_mem [QueueDepth];
    logic [QueuePtrW-1:0] r_wr, r_rd;
    logic [QueueCntW-1:0] r_cnt;

    assign o_full  = (r_cnt == QueueCntW'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QueuePtrW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QueuePtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QueueCntW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QueueCntW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### rtl/elfc_back.sv
`default_nettype none

module elfc_back
    import elfc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_empty,
    input  t_cmd      i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_ready
);

    // slot of a transmit beat in the full start/escape/data sequence
    localparam logic [1:0] SlotStart = 2'd0;
    localparam logic [1:0] SlotFirst = 2'd1;
    localparam logic [1:0] SlotLow   = 2'd2;

    logic [1:0] r_step, n_step;
    logic       r_valid;
    t_out_item  r_out;
    t_out_item  beat;
    logic [1:0] slot;
    logic       hi;
    logic       load;
    logic       have;

    assign load = !r_valid || i_out_ready;
    assign have = !i_empty;
    assign hi   = (i_head.tx_byte >= ByteStart);
    assign slot = r_step + (i_head.tx_start ? 2'd0 : 2'd1);

    always_comb begin
        beat = i_head.res;
        if (i_head.is_tx) begin
            beat            = '0;
            beat.event_res  = EV_LINK;
            beat.link_valid = 1'b1;
            case (slot)
                SlotStart: begin
                    beat.link_byte = ByteStart;
                end
                SlotFirst: begin
                    beat.link_byte = hi ? ByteEsc : i_head.tx_byte;
                    beat.last      = !hi;
                end
                SlotLow: begin
                    beat.link_byte = i_head.tx_byte & ByteMask7;
                    beat.last      = 1'b1;
                end
                default: begin
                    beat.last = 1'b1;
                end
            endcase
        end else begin
            beat.last = 1'b1;
        end
    end

    assign o_pop = load && have && beat.last;

    always_comb begin
        n_step = r_step;
        if (load && have) begin
            n_step = beat.last ? 2'd0 : r_step + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else begin
            r_step <= n_step;
            if (load) begin
                r_valid <= have;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && have) begin
            r_out <= beat;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

### rtl/elfc_checker.sv
`default_nettype none

`include "escaped_length_frame_link_codec_top_assert.svh"

module elfc_checker
    import elfc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_out_valid,
    input logic      i_out_ready,
    input t_out_item i_out_data
);

    logic out_wait;
    logic out_take;
    logic out_link;
    logic ctrl_beat;
    logic single_quiet;

    assign out_wait     = i_out_valid && !i_out_ready;
    assign out_take     = i_out_valid && i_out_ready;
    assign out_link     = i_out_valid && (i_out_data.event_res == EV_LINK);
    assign ctrl_beat    = i_out_valid && ((i_out_data.event_res == EV_ACK) ||
                                          (i_out_data.event_res == EV_ERROR) ||
                                          (i_out_data.event_res == EV_OVERFLOW));
    assign single_quiet = i_out_data.last && !i_out_data.link_valid;

    `ELFC_ASSERT(a_out_hold, i_clk, i_rst_n, out_wait |=> i_out_valid)

    `ELFC_ASSERT(a_out_stable, i_clk, i_rst_n, out_wait |=> $stable(i_out_data))

    // a transmit burst continues on the very next cycle
    `ELFC_ASSERT(a_tx_burst, i_clk, i_rst_n, out_take && !i_out_data.last |=> out_link)

    // ack, error and overflow are single beats that send nothing
    `ELFC_ASSERT(a_ctrl_beat, i_clk, i_rst_n, ctrl_beat |-> single_quiet)

    `ELFC_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind escaped_length_frame_link_codec_top elfc_checker u_elfc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);

`default_nettype wire
